/* hdl/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and datapath widths of the triangle pick classifier.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // Coordinate and index widths of the item fields, and the face count width.
  localparam int CW  = 16;
  localparam int IW  = 13;
  localparam int KW  = 12;
  localparam int FCW = 14;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int MAX_FACES_DEF    = 8192;

  // Datapath widths derived from the coordinate and corner index widths.
  localparam int EW  = CW + 1;          // edge difference
  localparam int PW  = 2 * EW;          // cross term product
  localparam int DW  = PW + 1;          // cross component difference
  localparam int AW  = PW;              // cross component magnitude
  localparam int HW  = (AW + 1) / 2;    // upper half for squaring
  localparam int LW  = AW - HW;         // lower half for squaring
  localparam int PPW = 2 * HW;          // partial product
  localparam int SQW = 2 * AW;          // squared component
  localparam int NW  = SQW + 2;         // squared norm
  localparam int RW  = NW / 2;          // area (square root)
  localparam int RMW = NW + 1;          // square root remainder
  localparam int TW  = RW + 2;          // sum of three areas
  localparam int VWW = 3 * CW;          // vertex word
  localparam int FWW = 3 * KW;          // face word

  // Pipeline depth: stages carrying item state, and accept-to-result edges.
  localparam int MD  = 9 + RW;
  localparam int LAT = MD + 1;

  typedef enum logic [1:0] {
    OP_LOAD_VERTEX = 2'd0,
    OP_LOAD_FACE   = 2'd1,
    OP_PICK        = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_FACE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FACE   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  localparam logic REG_SELECTION_MODE = 1'b0;
  localparam logic REG_FACE_COUNT     = 1'b1;

  typedef struct packed {
    logic          stale;
    logic [IW-1:0] idx;
    logic [KW-1:0] ca;
    logic [KW-1:0] cb;
    logic [KW-1:0] cc;
  } meta_t;

endpackage

/* hdl/triangle_pick_classifier.sv */
// ----------------------------------------------------------------------------
// triangle_pick_classifier
// Pick classification of a point against a stored triangle by sub-areas.
// ----------------------------------------------------------------------------
// An item is accepted on a clock edge with start high and busy low. busy
// stays low: the block takes one item every cycle. Opcode load vertex and
// load face write one entry of the vertex or face table and give no result.
// A pick item reads the face, its three vertices, forms the three
// sub-triangle areas and reports the dominant vertex or the face.
// A pick result shows on hit_kind and hit_index with done high for exactly
// one cycle; it is taken at the edge that ends that cycle. The depth is set
// by the square root pipeline, one result bit per stage (35 stages), after
// the face read, the vertex read and the cross product and squaring stages.
// Results come out in pick order and loads between picks are seen in order.
// The receiver cannot stall, so nothing ever backs up.
// Configuration (selection mode, face count) is written through write_enable,
// reg_index and reg_data; the user must do so only while no pick is in
// flight, as the block does not enforce it.
// Reset clears the registers and empties the pipeline; the tables are not
// cleared and an entry is undefined until loaded.
module triangle_pick_classifier #(
  parameter int MAX_VERTICES = tpc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_FACES    = tpc_pkg::MAX_FACES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [tpc_pkg::IW-1:0]       entry_index,
  input  logic signed [tpc_pkg::CW-1:0] coord_x,
  input  logic signed [tpc_pkg::CW-1:0] coord_y,
  input  logic signed [tpc_pkg::CW-1:0] coord_z,
  input  logic [tpc_pkg::KW-1:0]       corner_a,
  input  logic [tpc_pkg::KW-1:0]       corner_b,
  input  logic [tpc_pkg::KW-1:0]       corner_c,
  input  logic                         write_enable,
  input  logic                         reg_index,
  input  logic [tpc_pkg::FCW-1:0]      reg_data,
  output logic                         done,
  output logic [1:0]                   hit_kind,
  output logic [tpc_pkg::IW-1:0]       hit_index
);
  import tpc_pkg::*;

  localparam int VA = $clog2(MAX_VERTICES);
  localparam int FA = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int SQ_END = 8 + RW;

  logic [1:0]     sel_mode;
  logic [FCW-1:0] face_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_mode   <= '0;
      face_count <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_SELECTION_MODE: sel_mode   <= reg_data[1:0];
        REG_FACE_COUNT:     face_count <= reg_data;
        default: ;
      endcase
    end
  end

  logic accept, is_pick, ld_v, ld_f, stale_in;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_pick  = accept && (opcode == OP_PICK);
  assign ld_v     = accept && (opcode == OP_LOAD_VERTEX) && (32'(entry_index) < MAX_VERTICES);
  assign ld_f     = accept && (opcode == OP_LOAD_FACE) && (32'(entry_index) < MAX_FACES);
  assign stale_in = (FCW'(entry_index) >= face_count) || (32'(entry_index) >= MAX_FACES);

  // Tables. The vertex table is held twice so that three corners read at once.
  logic [FWW-1:0] fmem [MAX_FACES];
  logic [FWW-1:0] frd;
  logic [VWW-1:0] vmem_ab [MAX_VERTICES];
  logic [VWW-1:0] vmem_c  [MAX_VERTICES];
  logic [VWW-1:0] vrd_a, vrd_b, vrd_c;

  always_ff @(posedge clk) begin
    if (ld_f) begin
      fmem[FA'(entry_index)] <= {corner_c, corner_b, corner_a};
    end
    frd <= fmem[FA'(entry_index)];
  end

  always_ff @(posedge clk) begin
    if (ld_v) begin
      vmem_ab[VA'(entry_index)] <= {coord_z, coord_y, coord_x};
    end
    vrd_a <= vmem_ab[VA'(frd[KW-1:0])];
    vrd_b <= vmem_ab[VA'(frd[2*KW-1:KW])];
  end

  always_ff @(posedge clk) begin
    if (ld_v) begin
      vmem_c[VA'(entry_index)] <= {coord_z, coord_y, coord_x};
    end
    vrd_c <= vmem_c[VA'(frd[3*KW-1:2*KW])];
  end

  // Item state travelling beside the datapath.
  meta_t                meta [1:MD];
  logic [MD:1]          vpipe;
  logic signed [CW-1:0] pp1 [3];
  logic signed [CW-1:0] pp2 [3];
  logic [2:0]           oor2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[MD-1:1], is_pick};
    end
  end

  always_ff @(posedge clk) begin
    meta[1].stale <= stale_in;
    meta[1].idx   <= entry_index;
    meta[1].ca    <= '0;
    meta[1].cb    <= '0;
    meta[1].cc    <= '0;
    meta[2].stale <= meta[1].stale;
    meta[2].idx   <= meta[1].idx;
    meta[2].ca    <= frd[KW-1:0];
    meta[2].cb    <= frd[2*KW-1:KW];
    meta[2].cc    <= frd[3*KW-1:2*KW];
    for (int i = 3; i <= MD; i++) begin
      meta[i] <= meta[i-1];
    end
    pp1[0]  <= coord_x;
    pp1[1]  <= coord_y;
    pp1[2]  <= coord_z;
    pp2     <= pp1;
    // A corner past the vertex table reads as the origin.
    oor2[0] <= 32'(frd[KW-1:0]) >= MAX_VERTICES;
    oor2[1] <= 32'(frd[2*KW-1:KW]) >= MAX_VERTICES;
    oor2[2] <= 32'(frd[3*KW-1:2*KW]) >= MAX_VERTICES;
  end

  // Sub-triangles: area 0 is (P,B,C), area 1 is (A,P,C), area 2 is (A,B,P).
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];
  logic signed [CW-1:0] uu [3][3];
  logic signed [CW-1:0] vv [3][3];
  logic signed [CW-1:0] ww [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = oor2[0] ? '0 : $signed(vrd_a[i*CW +: CW]);
      pb[i] = oor2[1] ? '0 : $signed(vrd_b[i*CW +: CW]);
      pc[i] = oor2[2] ? '0 : $signed(vrd_c[i*CW +: CW]);
      uu[0][i] = pp2[i];
      vv[0][i] = pb[i];
      ww[0][i] = pc[i];
      uu[1][i] = pa[i];
      vv[1][i] = pp2[i];
      ww[1][i] = pc[i];
      uu[2][i] = pa[i];
      vv[2][i] = pb[i];
      ww[2][i] = pp2[i];
    end
  end

  logic signed [EW-1:0] e1 [3][3];
  logic signed [EW-1:0] e2 [3][3];
  logic signed [PW-1:0] pr [3][6];

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int i = 0; i < 3; i++) begin
        e1[g][i] <= EW'(vv[g][i]) - EW'(uu[g][i]);
        e2[g][i] <= EW'(ww[g][i]) - EW'(uu[g][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      pr[g][0] <= e1[g][1] * e2[g][2];
      pr[g][1] <= e1[g][2] * e2[g][1];
      pr[g][2] <= e1[g][2] * e2[g][0];
      pr[g][3] <= e1[g][0] * e2[g][2];
      pr[g][4] <= e1[g][0] * e2[g][1];
      pr[g][5] <= e1[g][1] * e2[g][0];
    end
  end

  logic signed [DW-1:0] dif [3][3];
  logic [AW-1:0]        mag [3][3];
  logic [PPW-1:0]       phh [3][3];
  logic [PPW-1:0]       phl [3][3];
  logic [PPW-1:0]       pll [3][3];
  logic [SQW-1:0]       sq  [3][3];

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < 3; c++) begin
        dif[g][c] = DW'(pr[g][2*c]) - DW'(pr[g][2*c+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < 3; c++) begin
        mag[g][c] <= dif[g][c][DW-1] ? AW'(-dif[g][c]) : AW'(dif[g][c]);
      end
    end
  end

  // Each magnitude is squared from three half-width products.
  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < 3; c++) begin
        phh[g][c] <= PPW'(mag[g][c][AW-1:LW]) * PPW'(mag[g][c][AW-1:LW]);
        phl[g][c] <= PPW'(mag[g][c][AW-1:LW]) * PPW'(mag[g][c][LW-1:0]);
        pll[g][c] <= PPW'(mag[g][c][LW-1:0]) * PPW'(mag[g][c][LW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < 3; c++) begin
        sq[g][c] <= (SQW'(phh[g][c]) << (2 * LW)) + (SQW'(phl[g][c]) << (LW + 1))
                    + SQW'(pll[g][c]);
      end
    end
  end

  // Square root, one root bit per stage, most significant first.
  logic [RMW-1:0] rem_q  [3][0:RW];
  logic [RW-1:0]  root_q [3][0:RW];

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      rem_q[g][0]  <= RMW'(sq[g][0]) + RMW'(sq[g][1]) + RMW'(sq[g][2]);
      root_q[g][0] <= '0;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_area
    for (genvar s = 1; s <= RW; s++) begin : g_root
      localparam int K = RW - s;
      logic [RMW-1:0] trial;

      assign trial = (RMW'(root_q[g][s-1]) << (K + 1)) + (RMW'(1) << (2 * K));

      always_ff @(posedge clk) begin
        if (rem_q[g][s-1] >= trial) begin
          rem_q[g][s]  <= rem_q[g][s-1] - trial;
          root_q[g][s] <= root_q[g][s-1] | (RW'(1) << K);
        end else begin
          rem_q[g][s]  <= rem_q[g][s-1];
          root_q[g][s] <= root_q[g][s-1];
        end
      end
    end
  end

  // Largest area, first one wins on ties.
  logic [RW-1:0] amax_c, amax_q;
  logic [1:0]    best_c, best_q;
  logic [TW-1:0] total_q;

  always_comb begin
    amax_c = root_q[0][RW];
    best_c = 2'd0;
    if (root_q[1][RW] > amax_c) begin
      amax_c = root_q[1][RW];
      best_c = 2'd1;
    end
    if (root_q[2][RW] > amax_c) begin
      amax_c = root_q[2][RW];
      best_c = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    amax_q  <= amax_c;
    best_q  <= best_c;
    total_q <= TW'(root_q[0][RW]) + TW'(root_q[1][RW]) + TW'(root_q[2][RW]);
  end

  // The weight threshold of 0.8 is tested as 5 * max > 4 * total.
  logic [TW+1:0] amax5, tot4;
  logic          vert;
  logic [KW-1:0] corner_sel;
  kind_t         kind_next;
  logic [IW-1:0] index_next;

  always_comb begin
    amax5 = ((TW+2)'(amax_q) << 2) + (TW+2)'(amax_q);
    tot4  = (TW+2)'(total_q) << 2;
    if (total_q == '0) begin
      vert = (sel_mode == MODE_VERTEX);
    end else if (sel_mode == MODE_VERTEX) begin
      vert = (amax_q != '0);
    end else if (sel_mode == MODE_FACE) begin
      vert = 1'b0;
    end else begin
      vert = (amax5 > tot4);
    end
    case (best_q)
      2'd0:    corner_sel = meta[MD].ca;
      2'd1:    corner_sel = meta[MD].cb;
      default: corner_sel = meta[MD].cc;
    endcase
    if (meta[MD].stale) begin
      kind_next  = KIND_NONE;
      index_next = '0;
    end else if (vert) begin
      kind_next  = KIND_VERTEX;
      index_next = IW'(corner_sel);
    end else begin
      kind_next  = KIND_FACE;
      index_next = meta[MD].idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[MD];
    end
  end

  always_ff @(posedge clk) begin
    hit_kind  <= kind_next;
    hit_index <= index_next;
  end

`ifndef SYNTHESIS
  a_done_from_pick : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (opcode == OP_PICK), LAT))
    else $error("result without a matching pick item");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    (done && (hit_kind == KIND_NONE)) |-> (hit_index == '0))
    else $error("stale pick reported a nonzero index");

  a_face_mode : assert property (@(posedge clk) disable iff (rst)
    (done && (hit_kind == KIND_VERTEX)) |-> (sel_mode != MODE_FACE))
    else $error("vertex reported in faces-only mode");

  // A stale pick may read a face that was never loaded, so only live picks count.
  a_root_exact : assert property (@(posedge clk) disable iff (rst)
    (vpipe[SQ_END] && !meta[SQ_END].stale)
    |-> (rem_q[0][RW] <= (RMW'(root_q[0][RW]) << 1)))
    else $error("square root remainder out of range");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle pick classifier. Vertex and face
// loads fill the tables, and pick items are checked against a local
// exact-integer model of the sub-triangle areas and the selection rules.
// The bench starts with a directed table and then runs random phases, each
// with its own selection mode and face count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    logic [1:0]           op;
    logic [IW-1:0]        idx;
    logic signed [CW-1:0] x, y, z;
    logic [KW-1:0]        a, b, c;
  } item_t;

  typedef struct {
    kind_t         kind;
    logic [IW-1:0] index;
  } hit_t;

  typedef struct {
    logic           is_cfg;
    logic           reg_sel;
    logic [FCW-1:0] value;
    item_t          it;
    logic           typed;
    hit_t           hit;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic start, write_enable, reg_index;
  logic [1:0] opcode;
  logic [IW-1:0] entry_index;
  logic signed [CW-1:0] coord_x, coord_y, coord_z;
  logic [KW-1:0] corner_a, corner_b, corner_c;
  logic [FCW-1:0] reg_data;
  logic busy, done;
  logic [1:0] hit_kind;
  logic [IW-1:0] hit_index;

  // Mirror of the tables and registers.
  logic signed [CW-1:0] vtab [MAX_VERTICES_DEF][3];
  logic [KW-1:0] ftab [MAX_FACES_DEF][3];
  bit vert_ok [MAX_VERTICES_DEF];
  bit face_ok [MAX_FACES_DEF];
  int vert_list[$];
  int face_list[$];
  logic [1:0] mode_r;
  logic [FCW-1:0] fcount_r;

  hit_t pending_hits[$];
  row_t rows[$];
  int errors = 0;
  int quiet = 0;
  bit no_gaps = 0;

  triangle_pick_classifier dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] cross_mag(longint p, longint q, longint r, longint s);
    longint d;
    d = p * q - r * s;
    if (d < 0) d = -d;
    return 128'(d);
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] sub_area(longint u[3], longint v[3], longint w[3]);
    longint e1[3], e2[3];
    logic [127:0] cx, cy, cz;
    for (int i = 0; i < 3; i++) begin
      e1[i] = v[i] - u[i];
      e2[i] = w[i] - u[i];
    end
    cx = cross_mag(e1[1], e2[2], e1[2], e2[1]);
    cy = cross_mag(e1[2], e2[0], e1[0], e2[2]);
    cz = cross_mag(e1[0], e2[1], e1[1], e2[0]);
    return root_floor(cx * cx + cy * cy + cz * cz);
  endfunction

  function automatic hit_t classify_pick(item_t it);
    hit_t h;
    longint pa[3], pb[3], pc[3], pp[3];
    logic [KW-1:0] cn[3];
    logic [127:0] aa, ab, ac, total, amax;
    int best;
    bit vert;
    if (it.idx >= fcount_r || it.idx >= MAX_FACES_DEF) begin
      h.kind = KIND_NONE;
      h.index = '0;
      return h;
    end
    for (int i = 0; i < 3; i++) cn[i] = ftab[it.idx][i];
    for (int i = 0; i < 3; i++) begin
      pa[i] = vtab[cn[0]][i];
      pb[i] = vtab[cn[1]][i];
      pc[i] = vtab[cn[2]][i];
    end
    pp[0] = it.x;
    pp[1] = it.y;
    pp[2] = it.z;
    aa = sub_area(pp, pb, pc);
    ab = sub_area(pa, pp, pc);
    ac = sub_area(pa, pb, pp);
    total = aa + ab + ac;
    best = 0;
    if (total == 0) begin
      vert = (mode_r == MODE_VERTEX);
    end else begin
      amax = aa;
      if (ab > amax) begin
        amax = ab;
        best = 1;
      end
      if (ac > amax) begin
        amax = ac;
        best = 2;
      end
      if (mode_r == MODE_VERTEX) vert = (amax != 0);
      else if (mode_r == MODE_FACE) vert = 0;
      else vert = (amax * 5 > total * 4);
    end
    if (vert) begin
      h.kind = KIND_VERTEX;
      h.index = IW'(cn[best]);
    end else begin
      h.kind = KIND_FACE;
      h.index = it.idx;
    end
    return h;
  endfunction

  // Updates the mirror for an accepted item and queues the expected hit.
  function automatic void apply_item(item_t it, logic typed, hit_t typed_hit);
    hit_t h;
    if (it.op == OP_LOAD_VERTEX && it.idx < MAX_VERTICES_DEF) begin
      vtab[it.idx][0] = it.x;
      vtab[it.idx][1] = it.y;
      vtab[it.idx][2] = it.z;
      if (!vert_ok[it.idx]) vert_list = {vert_list, int'(it.idx)};
      vert_ok[it.idx] = 1;
    end else if (it.op == OP_LOAD_FACE) begin
      ftab[it.idx][0] = it.a;
      ftab[it.idx][1] = it.b;
      ftab[it.idx][2] = it.c;
      if (!face_ok[it.idx]) face_list = {face_list, int'(it.idx)};
      face_ok[it.idx] = 1;
    end else if (it.op == OP_PICK) begin
      h = typed ? typed_hit : classify_pick(it);
      pending_hits = {pending_hits, h};
    end
  endfunction

  task automatic send_item(item_t it, logic typed, hit_t typed_hit);
    @(negedge clk);
    start = 1'b1;
    opcode = it.op;
    entry_index = it.idx;
    coord_x = it.x;
    coord_y = it.y;
    coord_z = it.z;
    corner_a = it.a;
    corner_b = it.b;
    corner_c = it.c;
    do @(posedge clk); while (busy);
    apply_item(it, typed, typed_hit);
  endtask

  task automatic idle_gap();
    int n;
    if (no_gaps || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 17);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(logic sel, logic [FCW-1:0] value);
    @(negedge clk);
    start = 1'b0;
    wait (pending_hits.size() == 0);
    repeat (LAT + 5) @(posedge clk);
    @(negedge clk);
    write_enable = 1'b1;
    reg_index = sel;
    reg_data = value;
    @(negedge clk);
    write_enable = 1'b0;
    if (sel == REG_SELECTION_MODE) mode_r = value[1:0];
    else fcount_r = value;
  endtask

  function automatic item_t mk(logic [1:0] op, int idx, int x, int y, int z,
                               int a = 0, int b = 0, int c = 0);
    item_t it;
    it.op = op;
    it.idx = IW'(idx);
    it.x = CW'(x);
    it.y = CW'(y);
    it.z = CW'(z);
    it.a = KW'(a);
    it.b = KW'(b);
    it.c = KW'(c);
    return it;
  endfunction

  function automatic void add_row(item_t it, logic typed = 0, kind_t k = KIND_NONE,
                                  int ix = 0);
    row_t r;
    r.is_cfg = 0;
    r.it = it;
    r.typed = typed;
    r.hit.kind = k;
    r.hit.index = IW'(ix);
    rows = {rows, r};
  endfunction

  function automatic void add_cfg(logic sel, int value);
    row_t r;
    r.is_cfg = 1;
    r.reg_sel = sel;
    r.value = FCW'(value);
    r.typed = 0;
    rows = {rows, r};
  endfunction

  function automatic int small_coord();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2047) - 1024;
    return $urandom;
  endfunction

  function automatic int pick_index();
    int f;
    if (fcount_r < MAX_FACES_DEF && $urandom_range(0, 6) == 0)
      return $urandom_range(fcount_r, MAX_FACES_DEF - 1);
    repeat (8) begin
      f = face_list[$urandom_range(0, face_list.size() - 1)];
      if (f < fcount_r) return f;
    end
    if (fcount_r < MAX_FACES_DEF) return $urandom_range(fcount_r, MAX_FACES_DEF - 1);
    return face_list[0];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel, f, w0, w1, w2, cn;
    longint s[3];
    sel = $urandom_range(0, 99);
    it = mk(OP_LOAD_VERTEX, 0, small_coord(), small_coord(), small_coord());
    it.a = KW'($urandom);
    it.b = KW'($urandom);
    it.c = KW'($urandom);
    it.idx = ($urandom_range(0, 4) == 0) ? IW'($urandom) : IW'($urandom_range(0, 31));
    if (sel < 25) return it;
    if (sel < 40) begin
      it.op = OP_LOAD_FACE;
      it.a = KW'(vert_list[$urandom_range(0, vert_list.size() - 1)]);
      it.b = KW'(vert_list[$urandom_range(0, vert_list.size() - 1)]);
      it.c = KW'(vert_list[$urandom_range(0, vert_list.size() - 1)]);
      return it;
    end
    if (sel < 95) begin
      it.op = OP_PICK;
      f = pick_index();
      it.idx = IW'(f);
      if (f < MAX_FACES_DEF && face_ok[f] && $urandom_range(0, 4) != 0) begin
        w0 = $urandom_range(0, 255);
        w1 = $urandom_range(0, 255);
        w2 = $urandom_range(0, 255);
        cn = $urandom_range(0, 2);
        // Lean on one corner now and then so that vertex picks show up.
        if ($urandom_range(0, 1) == 0) begin
          if (cn == 0) w0 += 3000;
          else if (cn == 1) w1 += 3000;
          else w2 += 3000;
        end
        for (int i = 0; i < 3; i++)
          s[i] = (longint'(vtab[ftab[f][0]][i]) * w0 + longint'(vtab[ftab[f][1]][i]) * w1
                  + longint'(vtab[ftab[f][2]][i]) * w2) / (w0 + w1 + w2 + 1);
        it.x = CW'(s[0]);
        it.y = CW'(s[1]);
        it.z = CW'(s[2]);
      end
      return it;
    end
    it.op = 2'd3;
    return it;
  endfunction

  always @(posedge clk) begin
    hit_t e;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected hit: hit_kind %0d hit_index %0d", hit_kind, hit_index);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (hit_kind !== e.kind) begin
          $error("hit_kind: expected %0d, got %0d", e.kind, hit_kind);
          errors++;
        end
        if (hit_index !== e.index) begin
          $error("hit_index: expected %0d, got %0d", e.index, hit_index);
          errors++;
        end
      end
    end
  end

  // A cycle counts as active when an item or a hit is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    hit_t none_hit;
    int fc_fixed[6] = '{8192, 16, 1, 16383, 0, 8191};
    rst = 1'b1;
    start = 1'b0;
    write_enable = 1'b0;
    reg_index = REG_SELECTION_MODE;
    reg_data = '0;
    opcode = OP_LOAD_VERTEX;
    entry_index = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    corner_a = '0;
    corner_b = '0;
    corner_c = '0;
    mode_r = MODE_AUTO;
    fcount_r = '0;
    none_hit.kind = KIND_NONE;
    none_hit.index = '0;

    // Registers come out of reset at auto mode and no faces, so picks are stale.
    add_row(mk(OP_PICK, 0, 0, 0, 0), 1, KIND_NONE, 0);
    add_row(mk(OP_PICK, 8191, 0, 0, 0), 1, KIND_NONE, 0);
    add_row(mk(OP_LOAD_VERTEX, 0, 0, 0, 0));
    add_row(mk(OP_LOAD_VERTEX, 1, 256, 0, 0));
    add_row(mk(OP_LOAD_VERTEX, 2, 0, 256, 0));
    add_row(mk(OP_LOAD_VERTEX, 3, 32767, -32768, 32767));
    add_row(mk(OP_LOAD_VERTEX, 4095, -32768, 32767, -32768));
    add_row(mk(OP_LOAD_VERTEX, 8191, 1, 1, 1));
    add_row(mk(OP_LOAD_FACE, 0, 0, 0, 0, 0, 1, 2));
    add_row(mk(OP_LOAD_FACE, 8191, 0, 0, 0, 3, 4095, 0));
    add_row(mk(OP_LOAD_FACE, 1, 0, 0, 0, 0, 0, 0));
    add_row(mk(2'd3, 0, 0, 0, 0));
    add_cfg(REG_FACE_COUNT, 8192);
    add_row(mk(OP_PICK, 0, 0, 0, 0), 1, KIND_VERTEX, 0);
    add_row(mk(OP_PICK, 0, 85, 85, 0));
    // A face with all corners at one point has zero total area.
    add_row(mk(OP_PICK, 1, 100, -7, 3), 1, KIND_FACE, 1);
    add_row(mk(OP_PICK, 8191, 32767, 32767, -32768));
    add_row(mk(OP_PICK, 8191, -32768, -32768, 32767));
    add_cfg(REG_SELECTION_MODE, MODE_VERTEX);
    add_row(mk(OP_PICK, 1, 100, -7, 3), 1, KIND_VERTEX, 0);
    add_row(mk(OP_PICK, 0, 85, 85, 0));
    add_cfg(REG_SELECTION_MODE, MODE_FACE);
    add_row(mk(OP_PICK, 0, 0, 0, 0), 1, KIND_FACE, 0);
    add_cfg(REG_SELECTION_MODE, 3);
    add_row(mk(OP_PICK, 0, 0, 0, 0), 1, KIND_VERTEX, 0);
    add_cfg(REG_FACE_COUNT, 8191);
    add_row(mk(OP_PICK, 8191, 0, 0, 0), 1, KIND_NONE, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].reg_sel, rows[i].value);
      end else begin
        send_item(rows[i].it, rows[i].typed, rows[i].hit);
        idle_gap();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_SELECTION_MODE, (p < 4) ? p : $urandom_range(0, 3));
      write_reg(REG_FACE_COUNT, (p < 6) ? fc_fixed[p] :
                ($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 16383)));
      no_gaps = (p == PHASES - 1);
      repeat (PHASE_ITEMS) begin
        send_item(random_item(), 0, none_hit);
        idle_gap();
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait (pending_hits.size() == 0);
    repeat (LAT + 5) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
